// ===== hdl/pcst_pkg.sv =====
// Shared types and constants for the crop, scale and transpose pixel block.
`timescale 1ns / 1ps

package pcst_pkg;

  // Preview geometry and source limits
  localparam int unsigned PREVIEW_SIDE   = 240;
  localparam int unsigned MAX_SOURCE_DIM = 4096;

  // Fixed field widths
  localparam int unsigned SRC_W     = 12;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned COLOR_W   = 16;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;

  // Divider geometry: quotient is always below PREVIEW_SIDE
  localparam int unsigned QW     = $clog2(PREVIEW_SIDE);
  localparam int unsigned PS_W   = $clog2(PREVIEW_SIDE + 1);
  localparam int unsigned PROD_W = DIM_W + PS_W;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 1'b0,
    CFG_SRC_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [SRC_W-1:0] src_x;
    logic [SRC_W-1:0] src_y;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
  } pix_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] color;
  } pix_out_t;

  // Crop geometry derived from the source size
  typedef struct packed {
    logic [DIM_W-1:0] side;
    logic [DIM_W-1:0] cx;
    logic [DIM_W-1:0] cy;
  } geom_t;

  // One lane of the restoring divider: partial remainder and the dividend
  // bits still to shift in, which are replaced by quotient bits
  typedef struct packed {
    logic [DIM_W-1:0] rem;
    logic [QW-1:0]    qd;
  } div_lane_t;

  typedef struct packed {
    div_lane_t          x;
    div_lane_t          y;
    logic [COLOR_W-1:0] color;
  } div_t;

endpackage

// ===== hdl/pcst_geom.sv =====
// Source size registers and centred square crop geometry.
`timescale 1ns / 1ps

module pcst_geom (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcst_pkg::DIM_W-1:0]      cfg_data_i,
  output pcst_pkg::geom_t                 geom_o
);

  logic [pcst_pkg::DIM_W-1:0] width_q, height_q;
  logic [pcst_pkg::DIM_W-1:0] clamped;
  logic [pcst_pkg::DIM_W-1:0] full_min, sw, sh, side;
  logic                       halve;

  assign cfg_ready_o = 1'b1;

  assign clamped = (cfg_data_i > pcst_pkg::DIM_W'(pcst_pkg::MAX_SOURCE_DIM)) ?
                   pcst_pkg::DIM_W'(pcst_pkg::MAX_SOURCE_DIM) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pcst_pkg::WIDTH_RST;
      height_q <= pcst_pkg::HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pcst_pkg::cfg_idx_e'(cfg_index_i))
        pcst_pkg::CFG_SRC_WIDTH:  width_q  <= clamped;
        pcst_pkg::CFG_SRC_HEIGHT: height_q <= clamped;
      endcase
    end
  end

  // Decoder halves the frame when half the short side still covers the preview
  always_comb begin
    full_min = (width_q < height_q) ? width_q : height_q;
    halve    = (full_min >> 1) >= pcst_pkg::DIM_W'(pcst_pkg::PREVIEW_SIDE);
    sw       = halve ? (width_q >> 1) : width_q;
    sh       = halve ? (height_q >> 1) : height_q;
    side     = (sw < sh) ? sw : sh;
    geom_o.side = side;
    geom_o.cx   = (sw - side) >> 1;
    geom_o.cy   = (sh - side) >> 1;
  end

  a_side_le_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    geom_o.side <= pcst_pkg::DIM_W'(pcst_pkg::MAX_SOURCE_DIM))
    else $error("crop side above source limit");

  a_crop_in_x : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (geom_o.cx + geom_o.side) <= width_q)
    else $error("horizontal crop exceeds frame");

  a_crop_in_y : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (geom_o.cy + geom_o.side) <= height_q)
    else $error("vertical crop exceeds frame");

endmodule

// ===== hdl/pcst_cell.sv =====
// One restoring division step for both coordinates, with its pipeline register.
`timescale 1ns / 1ps

module pcst_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pcst_pkg::DIM_W-1:0]  side_i,
  input  logic                        up_valid_i,
  output logic                        up_ready_o,
  input  pcst_pkg::div_t              up_data_i,
  output logic                        dn_valid_o,
  input  logic                        dn_ready_i,
  output pcst_pkg::div_t              dn_data_o
);

  logic           valid_q;
  pcst_pkg::div_t data_q, data_d;

  function automatic pcst_pkg::div_lane_t div_step(pcst_pkg::div_lane_t l,
                                                   logic [pcst_pkg::DIM_W-1:0] d);
    logic [pcst_pkg::DIM_W:0] r2;
    logic [pcst_pkg::DIM_W:0] diff;
    logic                     ge;
    pcst_pkg::div_lane_t      res;
    r2   = {l.rem, l.qd[pcst_pkg::QW-1]};
    diff = r2 - {1'b0, d};
    ge   = r2 >= {1'b0, d};
    res.rem = ge ? diff[pcst_pkg::DIM_W-1:0] : r2[pcst_pkg::DIM_W-1:0];
    res.qd  = {l.qd[pcst_pkg::QW-2:0], ge};
    return res;
  endfunction

  always_comb begin
    data_d.x     = div_step(up_data_i.x, side_i);
    data_d.y     = div_step(up_data_i.y, side_i);
    data_d.color = up_data_i.color;
  end

  assign up_ready_o = !valid_q || dn_ready_i;
  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      data_q <= data_d;
    end
  end

  a_rem_below_side : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && side_i != '0) |-> (data_q.x.rem < side_i && data_q.y.rem < side_i))
    else $error("partial remainder not below divisor");

endmodule

// ===== hdl/pixel_crop_scale_transpose_rgb565_core.sv =====
// An accepted pixel inside the crop passes through the offset stage, the scaling multiply,
// one divider cell per quotient bit and the output register, in that order, before it appears on the output.
// Throughput: one pixel per cycle while out_stall_i is low; the divider cells are fully pipelined.
// Pixels outside the crop leave a bubble and produce no transfer.
// Reset: asynchronous, active low; clears all valid bits and loads 640 x 480.
`timescale 1ns / 1ps

module pixel_crop_scale_transpose_rgb565_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pcst_pkg::pix_in_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pcst_pkg::pix_out_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pcst_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcst_pkg::DIM_W-1:0]      cfg_data_i
);

  localparam int unsigned NC = pcst_pkg::QW;

  pcst_pkg::geom_t geom;

  // Offset stage
  logic                       a_valid_q, a_valid_d, a_ready;
  logic [pcst_pkg::DIM_W-1:0] a_off_x_q, a_off_y_q, a_off_x_d, a_off_y_d;
  logic [pcst_pkg::COLOR_W-1:0] a_color_q, a_color_d;
  logic [pcst_pkg::DIM_W-1:0] sx, sy;
  logic                       in_crop;

  // Scaling stage
  logic                        b_valid_q, b_ready;
  pcst_pkg::div_t              b_data_q, b_data_d;
  logic [pcst_pkg::PROD_W-1:0] prod_x, prod_y;

  // Divider chain
  logic           c_valid [NC+1];
  logic           c_ready [NC+1];
  pcst_pkg::div_t c_data  [NC+1];

  // Output register
  logic               out_valid_q, out_ready;
  pcst_pkg::pix_out_t out_data_q, out_data_d;

  pcst_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .geom_o      (geom)
  );

  assign a_ready    = !a_valid_q || b_ready;
  assign in_stall_o = !a_ready;

  always_comb begin
    sx = {1'b0, in_data_i.src_x};
    sy = {1'b0, in_data_i.src_y};
    in_crop = (sx >= geom.cx) && (sx < geom.cx + geom.side) &&
              (sy >= geom.cy) && (sy < geom.cy + geom.side);
    a_valid_d = in_valid_i && in_crop;
    a_off_x_d = sx - geom.cx;
    a_off_y_d = sy - geom.cy;
    a_color_d = {in_data_i.red[7:3], in_data_i.green[7:2], in_data_i.blue[7:3]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_d && a_ready) begin
      a_off_x_q <= a_off_x_d;
      a_off_y_q <= a_off_y_d;
      a_color_q <= a_color_d;
    end
  end

  // Offset times preview side; top bits seed the remainder (always below side)
  always_comb begin
    prod_x = pcst_pkg::PROD_W'(a_off_x_q) * pcst_pkg::PROD_W'(pcst_pkg::PREVIEW_SIDE);
    prod_y = pcst_pkg::PROD_W'(a_off_y_q) * pcst_pkg::PROD_W'(pcst_pkg::PREVIEW_SIDE);
    b_data_d.x.rem = pcst_pkg::DIM_W'(prod_x >> pcst_pkg::QW);
    b_data_d.x.qd  = prod_x[pcst_pkg::QW-1:0];
    b_data_d.y.rem = pcst_pkg::DIM_W'(prod_y >> pcst_pkg::QW);
    b_data_d.y.qd  = prod_y[pcst_pkg::QW-1:0];
    b_data_d.color = a_color_q;
  end

  assign b_ready = !b_valid_q || c_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_ready) begin
      b_data_q <= b_data_d;
    end
  end

  assign c_valid[0] = b_valid_q;
  assign c_data[0]  = b_data_q;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    pcst_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .side_i     (geom.side),
      .up_valid_i (c_valid[i]),
      .up_ready_o (c_ready[i]),
      .up_data_i  (c_data[i]),
      .dn_valid_o (c_valid[i+1]),
      .dn_ready_i (c_ready[i+1]),
      .dn_data_o  (c_data[i+1])
    );
  end

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign c_ready[NC] = out_ready;

  // Transpose: preview row comes from the source column
  always_comb begin
    out_data_d.pixel_index = pcst_pkg::IDX_W'(
      32'(c_data[NC].x.qd) * 32'(pcst_pkg::PREVIEW_SIDE) + 32'(c_data[NC].y.qd));
    out_data_d.color = c_data[NC].color;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= c_valid[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_valid[NC] && out_ready) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_no_stall_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled with empty output register");

  a_quot_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid[NC] |-> (32'(c_data[NC].x.qd) < 32'(pcst_pkg::PREVIEW_SIDE) &&
                     32'(c_data[NC].y.qd) < 32'(pcst_pkg::PREVIEW_SIDE)))
    else $error("preview coordinate out of range");

  a_outside_dropped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !in_crop) |=> !a_valid_q)
    else $error("pixel outside crop entered pipeline");

endmodule
